// ----- src/fcl_pkg.sv -----
// ----------------------------------------------------------------------------
// fcl_pkg: shared types and constants
// Sizes, item kinds, sequencer states and Q16.16 helpers for the dense
// layer engine.
// ----------------------------------------------------------------------------
package fcl_pkg;

    localparam int MAX_BATCH = 16;
    localparam int MAX_IN    = 64;
    localparam int MAX_OUT   = 64;
    localparam int FRAC_BITS = 16;

    localparam int W_DEPTH = MAX_OUT * MAX_IN;
    localparam int X_DEPTH = MAX_BATCH * MAX_IN;
    localparam int B_DEPTH = MAX_OUT;
    localparam int W_AW    = $clog2(W_DEPTH);
    localparam int X_AW    = $clog2(X_DEPTH);
    localparam int B_AW    = $clog2(B_DEPTH);

    localparam logic signed [63:0] ACC_LIM = 64'sd1 <<< 62;
    localparam logic signed [63:0] I32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] I32_MIN = -64'sd2147483648;

    typedef enum logic [2:0] {
        KIND_WEIGHT = 3'd0,
        KIND_BIAS   = 3'd1,
        KIND_INPUT  = 3'd2,
        KIND_OGRAD  = 3'd3,
        KIND_CLEAR  = 3'd4,
        KIND_RD_GX  = 3'd5,
        KIND_RD_GW  = 3'd6,
        KIND_RD_GB  = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        CFG_BATCH = 2'd0,
        CFG_IN    = 2'd1,
        CFG_OUT   = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FWD_MAC,
        ST_FWD_DRAIN,
        ST_FWD_BIAS,
        ST_FWD_OUT,
        ST_G_RD,
        ST_G_M1,
        ST_G_M2,
        ST_G_W2,
        ST_G_BRD,
        ST_G_BWR,
        ST_RD_OUT
    } state_t;

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        if (v > I32_MAX) return 32'h7fff_ffff;
        if (v < I32_MIN) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic logic clip32(input logic signed [63:0] v);
        return (v > I32_MAX) || (v < I32_MIN);
    endfunction

endpackage

// ----- src/fully_connected_layer_engine.sv -----
// ----------------------------------------------------------------------------
// fully_connected_layer_engine: dense layer forward/backward in Q16.16
// Sequencer around one shared multiplier and six RAMs.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Weight, bias and
// plain input-element beats are stored as they are taken. The input element
// that completes a sample runs the forward pass: for each output row, one
// MAC a cycle through the shared multiplier, then pipeline drain, bias add
// and output, with one result beat per row. For an output-gradient beat
// each column does two multiplies and two read-modify-writes on the
// gradient RAMs, then the bias gradient is updated. Read beats give one
// result in the cycle right after they are taken. Result beats appear on
// out_valid for one cycle and cannot be held off. After reset and after a
// clear beat the engine sweeps the gradient RAMs with busy high; config
// writes are taken at any time.
// ----------------------------------------------------------------------------
module fully_connected_layer_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [6:0]         cfg_data,
    input  logic [2:0]         kind,
    input  logic [3:0]         sample,
    input  logic [5:0]         row,
    input  logic [5:0]         col,
    input  logic signed [31:0] value,
    output logic               out_valid,
    output logic signed [31:0] value_res,
    output logic [3:0]         sample_res,
    output logic [5:0]         position,
    output logic               last,
    output logic               saturated
);
    import fcl_pkg::*;

    state_t state_reg, state_next;

    // effective configuration, clamped on write
    logic [4:0] batch_reg;
    logic [6:0] in_reg, out_reg;

    // captured item
    kind_t             kind_reg;
    logic [3:0]        s_reg;
    logic [5:0]        r_reg;
    logic signed [31:0] v_reg;

    logic [5:0]  k_reg, k_next;
    logic [5:0]  j_reg, j_next;
    logic [W_AW-1:0] clr_reg, clr_next;
    logic signed [63:0] acc_reg, acc_next;
    logic sat_reg, sat_next;
    logic v1_reg, v2_reg, issue;

    logic accept, sok, rok, cok;
    kind_t kin;

    // RAM ports
    logic w_we, b_we, x_we, gx_we, gw_we, gb_we;
    logic w_re, b_re, x_re, gx_re, gw_re, gb_re;
    logic [W_AW-1:0] w_raddr, gw_waddr, gw_raddr;
    logic [X_AW-1:0] x_raddr, gx_waddr, gx_raddr;
    logic [B_AW-1:0] b_raddr, gb_waddr, gb_raddr;
    logic [31:0] gx_wdata, gw_wdata, gb_wdata;
    logic [31:0] w_rd, b_rd, x_rd, gx_rd, gw_rd, gb_rd;

    logic signed [31:0] mac_a, mac_b;
    logic signed [47:0] term;
    logic signed [63:0] acc_sum, gx_sum, gw_sum, gb_sum, bias_sum;
    logic k_last, j_last;

    assign kin    = kind_t'(kind);
    assign accept = start && (state_reg == ST_IDLE);
    assign sok    = {1'b0, sample} < batch_reg;
    assign rok    = {1'b0, row} < out_reg;
    assign cok    = {1'b0, col} < in_reg;
    assign k_last = {1'b0, k_reg} == (in_reg - 7'd1);
    assign j_last = {1'b0, j_reg} == (out_reg - 7'd1);

    fcl_ram #(.WIDTH(32), .DEPTH(W_DEPTH)) u_w (
        .clk(clk), .we(w_we), .waddr({row, col}), .wdata(value),
        .re(w_re), .raddr(w_raddr), .rdata(w_rd));
    fcl_ram #(.WIDTH(32), .DEPTH(B_DEPTH)) u_b (
        .clk(clk), .we(b_we), .waddr(row), .wdata(value),
        .re(b_re), .raddr(b_raddr), .rdata(b_rd));
    fcl_ram #(.WIDTH(32), .DEPTH(X_DEPTH)) u_x (
        .clk(clk), .we(x_we), .waddr({sample, col}), .wdata(value),
        .re(x_re), .raddr(x_raddr), .rdata(x_rd));
    fcl_ram #(.WIDTH(32), .DEPTH(X_DEPTH)) u_gx (
        .clk(clk), .we(gx_we), .waddr(gx_waddr), .wdata(gx_wdata),
        .re(gx_re), .raddr(gx_raddr), .rdata(gx_rd));
    fcl_ram #(.WIDTH(32), .DEPTH(W_DEPTH)) u_gw (
        .clk(clk), .we(gw_we), .waddr(gw_waddr), .wdata(gw_wdata),
        .re(gw_re), .raddr(gw_raddr), .rdata(gw_rd));
    fcl_ram #(.WIDTH(32), .DEPTH(B_DEPTH)) u_gb (
        .clk(clk), .we(gb_we), .waddr(gb_waddr), .wdata(gb_wdata),
        .re(gb_re), .raddr(gb_raddr), .rdata(gb_rd));

    fcl_mac u_mac (.clk(clk), .a(mac_a), .b(mac_b), .term(term));

    // sums for the accumulator and the gradient updates
    assign acc_sum  = acc_reg + 64'(term);
    assign bias_sum = acc_reg + 64'(signed'(b_rd));
    assign gx_sum   = 64'(signed'(gx_rd)) + 64'(term);
    assign gw_sum   = 64'(signed'(gw_rd)) + 64'(term);
    assign gb_sum   = 64'(signed'(gb_rd)) + 64'(v_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == W_AW'(W_DEPTH - 1)) state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    case (kin)
                        KIND_INPUT:
                            if (sok && cok && ({1'b0, col} == in_reg - 7'd1))
                                state_next = ST_FWD_MAC;
                        KIND_OGRAD:
                            if (sok && rok) state_next = ST_G_RD;
                        KIND_CLEAR:
                            state_next = ST_CLEAR;
                        KIND_RD_GX:
                            if (sok && cok) state_next = ST_RD_OUT;
                        KIND_RD_GW:
                            if (rok && cok) state_next = ST_RD_OUT;
                        KIND_RD_GB:
                            if (rok) state_next = ST_RD_OUT;
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_FWD_MAC:   if (k_last) state_next = ST_FWD_DRAIN;
            ST_FWD_DRAIN: if (!v1_reg && !v2_reg) state_next = ST_FWD_BIAS;
            ST_FWD_BIAS:  state_next = ST_FWD_OUT;
            ST_FWD_OUT:   state_next = j_last ? ST_IDLE : ST_FWD_MAC;
            ST_G_RD:      state_next = ST_G_M1;
            ST_G_M1:      state_next = ST_G_M2;
            ST_G_M2:      state_next = ST_G_W2;
            ST_G_W2:      state_next = k_last ? ST_G_BRD : ST_G_RD;
            ST_G_BRD:     state_next = ST_G_BWR;
            ST_G_BWR:     state_next = ST_IDLE;
            ST_RD_OUT:    state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // memory control, counters and datapath
    always_comb
    begin
        w_we = 1'b0; b_we = 1'b0; x_we = 1'b0;
        gx_we = 1'b0; gw_we = 1'b0; gb_we = 1'b0;
        w_re = 1'b0; b_re = 1'b0; x_re = 1'b0;
        gx_re = 1'b0; gw_re = 1'b0; gb_re = 1'b0;
        w_raddr  = {j_reg, k_reg};
        x_raddr  = {s_reg, k_reg};
        b_raddr  = j_reg;
        gx_raddr = {s_reg, k_reg};
        gw_raddr = {r_reg, k_reg};
        gb_raddr = r_reg;
        gx_waddr = {s_reg, k_reg};
        gw_waddr = {r_reg, k_reg};
        gb_waddr = r_reg;
        gx_wdata = sat32(gx_sum);
        gw_wdata = sat32(gw_sum);
        gb_wdata = sat32(gb_sum);
        mac_a = signed'(w_rd);
        mac_b = signed'(x_rd);
        issue = 1'b0;
        k_next = k_reg;
        j_next = j_reg;
        clr_next = clr_reg;
        acc_next = acc_reg;
        sat_next = sat_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                gw_we = 1'b1; gw_waddr = clr_reg; gw_wdata = '0;
                gx_we = clr_reg < W_AW'(X_DEPTH);
                gx_waddr = clr_reg[X_AW-1:0]; gx_wdata = '0;
                gb_we = clr_reg < W_AW'(B_DEPTH);
                gb_waddr = clr_reg[B_AW-1:0]; gb_wdata = '0;
                clr_next = clr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                k_next = '0;
                j_next = '0;
                clr_next = '0;
                if (start)
                begin
                    case (kin)
                        KIND_WEIGHT: w_we = rok && cok;
                        KIND_BIAS:   b_we = rok;
                        KIND_INPUT:  x_we = sok && cok;
                        KIND_RD_GX:
                        begin
                            gx_re = 1'b1; gx_raddr = {sample, col};
                        end
                        KIND_RD_GW:
                        begin
                            gw_re = 1'b1; gw_raddr = {row, col};
                        end
                        KIND_RD_GB:
                        begin
                            gb_re = 1'b1; gb_raddr = row;
                        end
                        default: ;
                    endcase
                end
            end
            ST_FWD_MAC:
            begin
                w_re = 1'b1; x_re = 1'b1; issue = 1'b1;
                if (k_reg == '0)
                begin
                    b_re = 1'b1;
                    acc_next = '0;
                    sat_next = 1'b0;
                end
                k_next = k_last ? '0 : k_reg + 1'b1;
            end
            ST_FWD_BIAS:
            begin
                if (bias_sum > ACC_LIM)
                begin
                    acc_next = ACC_LIM; sat_next = 1'b1;
                end
                else if (bias_sum < -ACC_LIM)
                begin
                    acc_next = -ACC_LIM; sat_next = 1'b1;
                end
                else
                begin
                    acc_next = bias_sum;
                end
            end
            ST_FWD_OUT:
            begin
                j_next = j_reg + 1'b1;
            end
            ST_G_RD:
            begin
                w_re = 1'b1; x_re = 1'b1; gx_re = 1'b1; gw_re = 1'b1;
                w_raddr = {r_reg, k_reg};
            end
            ST_G_M1:
            begin
                mac_a = v_reg; mac_b = signed'(w_rd);
            end
            ST_G_M2:
            begin
                mac_a = signed'(x_rd); mac_b = v_reg;
                gx_we = 1'b1;
            end
            ST_G_W2:
            begin
                gw_we = 1'b1;
                k_next = k_last ? '0 : k_reg + 1'b1;
            end
            ST_G_BRD:
            begin
                gb_re = 1'b1;
            end
            ST_G_BWR:
            begin
                gb_we = 1'b1;
            end
            default: ;
        endcase
        // accumulate stage of the forward pipeline
        if (v2_reg)
        begin
            if (acc_sum > ACC_LIM)
            begin
                acc_next = ACC_LIM; sat_next = 1'b1;
            end
            else if (acc_sum < -ACC_LIM)
            begin
                acc_next = -ACC_LIM; sat_next = 1'b1;
            end
            else
            begin
                acc_next = acc_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            batch_reg <= 5'd1;
            in_reg    <= 7'd64;
            out_reg   <= 7'd64;
            k_reg     <= '0;
            j_reg     <= '0;
            clr_reg   <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            j_reg     <= j_next;
            clr_reg   <= clr_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_BATCH:
                        batch_reg <= (cfg_data[4:0] == '0) ? 5'd1 :
                                     (cfg_data[4:0] > 5'(MAX_BATCH)) ? 5'(MAX_BATCH) :
                                     cfg_data[4:0];
                    CFG_IN:
                        in_reg <= (cfg_data == '0) ? 7'd1 :
                                  (cfg_data > 7'(MAX_IN)) ? 7'(MAX_IN) : cfg_data;
                    CFG_OUT:
                        out_reg <= (cfg_data == '0) ? 7'd1 :
                                   (cfg_data > 7'(MAX_OUT)) ? 7'(MAX_OUT) : cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        sat_reg <= sat_next;
        if (accept)
        begin
            kind_reg <= kin;
            s_reg    <= sample;
            r_reg    <= row;
            v_reg    <= value;
        end
    end

    // result beat
    always_comb
    begin
        busy       = state_reg != ST_IDLE;
        out_valid  = 1'b0;
        value_res  = '0;
        sample_res = '0;
        position   = '0;
        last       = 1'b0;
        saturated  = 1'b0;
        case (state_reg)
            ST_FWD_OUT:
            begin
                out_valid  = 1'b1;
                value_res  = sat32(acc_reg);
                sample_res = s_reg;
                position   = j_reg;
                last       = j_last;
                saturated  = sat_reg || clip32(acc_reg);
            end
            ST_RD_OUT:
            begin
                out_valid = 1'b1;
                last      = 1'b1;
                case (kind_reg)
                    KIND_RD_GX: value_res = gx_rd;
                    KIND_RD_GW: value_res = gw_rd;
                    default:    value_res = gb_rd;
                endcase
            end
            default: ;
        endcase
    end

endmodule

// ----- src/fcl_ram.sv -----
// ----------------------------------------------------------------------------
// fcl_ram: generic single-write, single-read RAM
// Registered read; read data holds when re is low.
// ----------------------------------------------------------------------------
module fcl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- src/fcl_mac.sv -----
// ----------------------------------------------------------------------------
// fcl_mac: shared multiplier
// One signed 32x32 product per cycle, registered, then rounded to Q32.16.
// ----------------------------------------------------------------------------
module fcl_mac (
    input  logic               clk,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [47:0] term
);
    import fcl_pkg::*;

    logic signed [63:0] prod_reg;
    logic signed [63:0] rnd;

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(a) * 64'(b);
    end

    // round half up, arithmetic shift floors
    assign rnd  = (prod_reg + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    assign term = rnd[47:0];

endmodule

// ----- src/fcl_checker.sv -----
// ----------------------------------------------------------------------------
// fcl_checker: port-level checks for the dense layer engine
// Result beats only while busy; a last beat closes the item.
// ----------------------------------------------------------------------------
module fcl_checker (
    input logic clk,
    input logic rst_n,
    input logic busy,
    input logic out_valid,
    input logic last
);

    a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> busy)
        else $error("result beat while not busy");

    a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |=> busy)
        else $error("engine went idle before last result beat");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |=> !out_valid && !busy)
        else $error("activity after last result beat");

endmodule

bind fully_connected_layer_engine fcl_checker u_fcl_checker (
    .clk(clk), .rst_n(rst_n), .busy(busy), .out_valid(out_valid), .last(last));

// ----- tb/sv/fcl_checker.sv -----
// ----------------------------------------------------------------------------
// fcl_scoreboard: prediction and compare for the dense layer engine
// Tracks config writes and accepted beats, keeps its own weight, bias,
// input and gradient stores, queues the result beats each one causes and
// checks every out_valid beat against the oldest queued one.
// ----------------------------------------------------------------------------
module fcl_scoreboard (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [6:0]         cfg_data,
    input  logic [2:0]         kind,
    input  logic [3:0]         sample,
    input  logic [5:0]         row,
    input  logic [5:0]         col,
    input  logic signed [31:0] value,
    input  logic               out_valid,
    input  logic signed [31:0] value_res,
    input  logic [3:0]         sample_res,
    input  logic [5:0]         position,
    input  logic               last,
    input  logic               saturated,
    output int                 errors,
    output int                 pending
);
    import fcl_pkg::*;

    typedef struct {
        logic signed [31:0] val;
        logic [3:0]         smp;
        logic [5:0]         pos;
        logic               lst;
        logic               sat;
    } result_beat_t;

    result_beat_t layer_results_q[$];

    logic signed [31:0] w_mem  [W_DEPTH];
    logic signed [31:0] b_mem  [B_DEPTH];
    logic signed [31:0] x_mem  [X_DEPTH];
    logic signed [31:0] gx_mem [X_DEPTH];
    logic signed [31:0] gw_mem [W_DEPTH];
    logic signed [31:0] gb_mem [B_DEPTH];

    int unsigned n_batch, n_in, n_out;

    function automatic int unsigned reg_limit(input int unsigned v, input int unsigned vmax);
        if (v == 0) return 1;
        if (v > vmax) return vmax;
        return v;
    endfunction

    // exact product, rounded half up to Q48.16 (>>> floors)
    function automatic longint q_mul(input logic signed [31:0] a, input logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b);
        return (p + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function automatic logic signed [31:0] clip_q32(input longint v, inout bit hit);
        if (v > 64'sd2147483647) begin
            hit = 1'b1;
            return 32'sh7fff_ffff;
        end
        if (v < -64'sd2147483648) begin
            hit = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic longint acc_step(input longint acc, input longint t, inout bit hit);
        longint s;
        longint lim;
        lim = longint'(1) <<< 62;
        s = acc + t;
        if (s > lim) begin
            hit = 1'b1;
            return lim;
        end
        if (s < -lim) begin
            hit = 1'b1;
            return -lim;
        end
        return s;
    endfunction

    function automatic bit field_ok(input string name, input longint e, input longint a);
        if (e != a)
            $display("%0t: mismatch on %s: expected %0h actual %0h", $time, name, e, a);
        return e == a;
    endfunction

    task automatic push_read(input logic signed [31:0] v);
        result_beat_t rb;
        rb = '{val: v, smp: '0, pos: '0, lst: 1'b1, sat: 1'b0};
        layer_results_q.push_back(rb);
    endtask

    task automatic predict_beat(input kind_t k, input int unsigned s, input int unsigned r,
                                input int unsigned c, input logic signed [31:0] v);
        bit s_in, r_in, c_in, hit, dummy;
        longint acc;
        result_beat_t rb;
        s_in = s < n_batch;
        r_in = r < n_out;
        c_in = c < n_in;
        case (k)
            KIND_WEIGHT: if (r_in && c_in) w_mem[r * MAX_IN + c] = v;
            KIND_BIAS:   if (r_in) b_mem[r] = v;
            KIND_INPUT:
            begin
                if (s_in && c_in) begin
                    x_mem[s * MAX_IN + c] = v;
                    if (c == n_in - 1) begin
                        for (int j = 0; j < n_out; j++) begin
                            acc = 0;
                            hit = 1'b0;
                            for (int i = 0; i < n_in; i++)
                                acc = acc_step(acc, q_mul(w_mem[j * MAX_IN + i],
                                                          x_mem[s * MAX_IN + i]), hit);
                            acc = acc_step(acc, longint'(b_mem[j]), hit);
                            rb.val = clip_q32(acc, hit);
                            rb.smp = s[3:0];
                            rb.pos = j[5:0];
                            rb.lst = (j == n_out - 1);
                            rb.sat = hit;
                            layer_results_q.push_back(rb);
                        end
                    end
                end
            end
            KIND_OGRAD:
            begin
                if (s_in && r_in) begin
                    for (int i = 0; i < n_in; i++) begin
                        gx_mem[s * MAX_IN + i] = clip_q32(longint'(gx_mem[s * MAX_IN + i])
                            + q_mul(v, w_mem[r * MAX_IN + i]), dummy);
                        gw_mem[r * MAX_IN + i] = clip_q32(longint'(gw_mem[r * MAX_IN + i])
                            + q_mul(x_mem[s * MAX_IN + i], v), dummy);
                    end
                    gb_mem[r] = clip_q32(longint'(gb_mem[r]) + longint'(v), dummy);
                end
            end
            KIND_CLEAR:
            begin
                foreach (gx_mem[i]) gx_mem[i] = '0;
                foreach (gw_mem[i]) gw_mem[i] = '0;
                foreach (gb_mem[i]) gb_mem[i] = '0;
            end
            KIND_RD_GX: if (s_in && c_in) push_read(gx_mem[s * MAX_IN + c]);
            KIND_RD_GW: if (r_in && c_in) push_read(gw_mem[r * MAX_IN + c]);
            default:    if (r_in) push_read(gb_mem[r]);
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_beat_t eb;
        bit ok;
        if (!rst_n) begin
            foreach (gx_mem[i]) gx_mem[i] = '0;
            foreach (gw_mem[i]) gw_mem[i] = '0;
            foreach (gb_mem[i]) gb_mem[i] = '0;
            n_batch = 1;
            n_in    = MAX_IN;
            n_out   = MAX_OUT;
            layer_results_q.delete();
            errors  = 0;
            pending = 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_BATCH: n_batch = reg_limit(cfg_data[4:0], MAX_BATCH);
                    CFG_IN:    n_in    = reg_limit(cfg_data, MAX_IN);
                    CFG_OUT:   n_out   = reg_limit(cfg_data, MAX_OUT);
                    default: ;
                endcase
            end
            if (out_valid) begin
                if (layer_results_q.size() == 0) begin
                    $display("%0t: result beat with none expected: value %0h", $time, value_res);
                    errors++;
                end
                else begin
                    eb = layer_results_q.pop_front();
                    ok = field_ok("value_res", eb.val, value_res);
                    ok = field_ok("sample_res", eb.smp, sample_res) && ok;
                    ok = field_ok("position", eb.pos, position) && ok;
                    ok = field_ok("last", eb.lst, last) && ok;
                    ok = field_ok("saturated", eb.sat, saturated) && ok;
                    if (!ok) errors++;
                end
            end
            if (start && !busy)
                predict_beat(kind_t'(kind), sample, row, col, value);
            pending = layer_results_q.size();
        end
    end

endmodule

// ----- tb/sv/fully_connected_layer_engine_tb.sv -----
// ----------------------------------------------------------------------------
// fully_connected_layer_engine_tb: top-level regression for the dense layer
// Runs the engine through several size settings (extremes included). Each
// setting loads the weights, biases and inputs it needs, then sends a mix
// of forward, gradient, clear and read beats; the checker predicts and
// compares every result beat.
// ----------------------------------------------------------------------------
module fully_connected_layer_engine_tb;
    import fcl_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    // margin that covers an output-gradient beat at full in_size, which gives no result
    localparam int QUIET_CYCLES = 4 * MAX_IN + 40;
    localparam int NUM_PHASES = 6;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [6:0]         cfg_data;
    logic [2:0]         kind;
    logic [3:0]         sample;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [31:0] value;
    logic               out_valid;
    logic signed [31:0] value_res;
    logic [3:0]         sample_res;
    logic [5:0]         position;
    logic               last;
    logic               saturated;
    int                 errors;
    int                 pending;

    // effective sizes of the current setting (registers after clamping)
    int unsigned eff_b, eff_i, eff_o;
    int          sent_total;
    longint      cycles;

    // raw register values per setting; zero and too-large values clamp
    int unsigned phase_b [NUM_PHASES] = '{2, 1, 16, 0, 31, 5};
    int unsigned phase_i [NUM_PHASES] = '{4, 1, 64, 0, 127, 9};
    int unsigned phase_o [NUM_PHASES] = '{3, 1, 64, 0, 127, 7};
    int          phase_n [NUM_PHASES] = '{28, 20, 8, 10, 6, 30};

    fully_connected_layer_engine i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .kind       (kind),
        .sample     (sample),
        .row        (row),
        .col        (col),
        .value      (value),
        .out_valid  (out_valid),
        .value_res  (value_res),
        .sample_res (sample_res),
        .position   (position),
        .last       (last),
        .saturated  (saturated)
    );

    fcl_scoreboard u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .kind       (kind),
        .sample     (sample),
        .row        (row),
        .col        (col),
        .value      (value),
        .out_valid  (out_valid),
        .value_res  (value_res),
        .sample_res (sample_res),
        .position   (position),
        .last       (last),
        .saturated  (saturated),
        .errors     (errors),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // watchdog: a hang or a missing result beat ends here
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int unsigned clamp_size(input int unsigned v, input int unsigned vmax);
        if (v == 0) return 1;
        if (v > vmax) return vmax;
        return v;
    endfunction

    // mostly values within +-8.0, sometimes the full 32-bit range
    function automatic logic [31:0] rand_q16();
        if ($urandom_range(9) < 7) return 32'($signed($urandom_range(1048576)) - 524288);
        return $urandom;
    endfunction

    // one beat: optional sender gap, then hold start until busy is low
    task automatic send_beat(input kind_t k, input int unsigned s, input int unsigned r,
                             input int unsigned c, input logic [31:0] v, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start  <= 1'b1;
        kind   <= k;
        sample <= s[3:0];
        row    <= r[5:0];
        col    <= c[5:0];
        value  <= v;
        do @(posedge clk); while (busy);
    endtask

    // sender holds off until every expected beat is in and the engine is idle
    task automatic drain();
        start <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    // back-to-back register writes, one per cycle, only while idle
    task automatic write_sizes(input int unsigned b, input int unsigned i, input int unsigned o);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BATCH;
        cfg_data  <= b[6:0];
        @(posedge clk);
        cfg_index <= CFG_IN;
        cfg_data  <= i[6:0];
        @(posedge clk);
        cfg_index <= CFG_OUT;
        cfg_data  <= o[6:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        eff_b = clamp_size(b, MAX_BATCH);
        eff_i = clamp_size(i, MAX_IN);
        eff_o = clamp_size(o, MAX_OUT);
    endtask

    // Fill every weight, bias and input the forward and gradient paths can
    // touch, so no unwritten entry is ever read. The final column of each
    // sample fires a forward pass, which the checker predicts as usual.
    task automatic load_layer();
        for (int r = 0; r < eff_o; r++) begin
            for (int c = 0; c < eff_i; c++)
                send_beat(KIND_WEIGHT, 0, r, c, rand_q16(), 0);
            send_beat(KIND_BIAS, 0, r, 0, rand_q16(), 0);
        end
        for (int s = 0; s < eff_b; s++)
            for (int c = 0; c < eff_i; c++)
                send_beat(KIND_INPUT, s, 0, c, rand_q16(), 0);
    endtask

    // Directed corner cases on the 2x4x3 setting: clipped forward sums at
    // both rails, gradient accumulation clipping, every read kind, a clear,
    // and beats with out-of-range indices that must be dropped.
    task automatic directed_beats();
        send_beat(KIND_WEIGHT, 0, 0, 0, 32'h7fff_ffff, 0);
        send_beat(KIND_WEIGHT, 0, 1, 0, 32'h8000_0000, 0);
        send_beat(KIND_BIAS, 0, 2, 0, 32'h8000_0000, 0);
        for (int c = 0; c < 4; c++)
            send_beat(KIND_INPUT, 0, 0, c, 32'h7fff_ffff, 0);
        send_beat(KIND_OGRAD, 0, 0, 0, 32'h7fff_ffff, 0);
        send_beat(KIND_OGRAD, 0, 0, 0, 32'h7fff_ffff, 0);
        send_beat(KIND_OGRAD, 1, 1, 0, 32'h8000_0000, 0);
        send_beat(KIND_RD_GX, 0, 0, 0, 0, 0);
        send_beat(KIND_RD_GW, 0, 0, 3, 0, 0);
        send_beat(KIND_RD_GB, 0, 0, 0, 0, 0);
        send_beat(KIND_RD_GB, 0, 1, 0, 0, 0);
        send_beat(KIND_INPUT, 15, 0, 3, 32'h1234_5678, 0);
        send_beat(KIND_RD_GW, 0, 63, 0, 0, 0);
        send_beat(KIND_RD_GX, 0, 0, 63, 0, 0);
        send_beat(KIND_OGRAD, 0, 63, 0, 32'h0001_0000, 0);
        send_beat(KIND_CLEAR, 0, 0, 0, 0, 0);
        send_beat(KIND_RD_GB, 0, 0, 0, 0, 0);
        send_beat(KIND_RD_GX, 1, 0, 2, 0, 0);
    endtask

    // random beat; counted only when the engine acts on it
    task automatic random_beat(input int idle_pct, output bit counted);
        int unsigned pick, s, r, c;
        kind_t k;
        pick = $urandom_range(99);
        if (pick < 8)       k = KIND_WEIGHT;
        else if (pick < 12) k = KIND_BIAS;
        else if (pick < 45) k = KIND_INPUT;
        else if (pick < 67) k = KIND_OGRAD;
        else if (pick < 71) k = KIND_CLEAR;
        else if (pick < 81) k = KIND_RD_GX;
        else if (pick < 91) k = KIND_RD_GW;
        else                k = KIND_RD_GB;
        s = ($urandom_range(99) < 85) ? $urandom_range(eff_b - 1) : $urandom_range(15);
        r = ($urandom_range(99) < 85) ? $urandom_range(eff_o - 1) : $urandom_range(63);
        c = ($urandom_range(99) < 85) ? $urandom_range(eff_i - 1) : $urandom_range(63);
        // complete a sample often, so forward passes dominate
        if (k == KIND_INPUT && $urandom_range(1) == 1) c = eff_i - 1;
        send_beat(k, s, r, c, rand_q16(), idle_pct);
        case (k)
            KIND_WEIGHT, KIND_RD_GW: counted = (r < eff_o) && (c < eff_i);
            KIND_BIAS, KIND_RD_GB:   counted = r < eff_o;
            KIND_INPUT, KIND_RD_GX:  counted = (s < eff_b) && (c < eff_i);
            KIND_OGRAD:              counted = (s < eff_b) && (r < eff_o);
            default:                 counted = 1'b1;
        endcase
    endtask

    initial
    begin
        bit counted;
        int done;
        int idle_pct;
        cycles     = 0;
        sent_total = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_BATCH;
        cfg_data   = '0;
        kind       = KIND_WEIGHT;
        sample     = '0;
        row        = '0;
        col        = '0;
        value      = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        // clearing sweep after reset keeps busy high; wait it out
        @(posedge clk);
        while (busy) @(posedge clk);

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_sizes(phase_b[p], phase_i[p], phase_o[p]);
            load_layer();
            if (p == 0) begin
                directed_beats();
                drain();
            end
            done = 0;
            while (done < phase_n[p]) begin
                // sender gaps: 21%, then 47%, then none
                if (sent_total < 34)      idle_pct = 21;
                else if (sent_total < 68) idle_pct = 47;
                else                      idle_pct = 0;
                random_beat(idle_pct, counted);
                if (counted) begin
                    done++;
                    sent_total++;
                end
            end
            drain();
        end

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- fully_connected_layer_engine.f -----
src/fcl_pkg.sv
src/fcl_ram.sv
src/fcl_mac.sv
src/fully_connected_layer_engine.sv
src/fcl_checker.sv
tb/sv/fcl_checker.sv
tb/sv/fully_connected_layer_engine_tb.sv
